// File: sv/mtiu_pkg.sv
// Shared types and constants for the machine trap and interrupt unit.
// No dependencies; every other file imports this package.
package mtiu_pkg;

   localparam int REQ_DATA_W = 80;   // 74 payload bits padded to whole bytes
   localparam int RSP_DATA_W = 144;  // 141 payload bits padded to whole bytes
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam int MASK_W     = 12;

   localparam logic [5:0] CAUSE_SW_INT  = 6'd3;
   localparam logic [5:0] CAUSE_TMR_INT = 6'd7;
   localparam logic [5:0] CAUSE_EXT_INT = 6'd11;
   localparam logic [1:0] MODE_MACHINE  = 2'd3;
   localparam logic [1:0] VEC_MODE_VECTORED = 2'd1;

   typedef enum logic [2:0] {
      ACT_SET_PENDING   = 3'd0,
      ACT_CLEAR_PENDING = 3'd1,
      ACT_EXCEPTION     = 3'd2,
      ACT_WRITE_ENABLE  = 3'd3,
      ACT_STEP          = 3'd4
   } action_type;

   typedef enum logic {
      CSR_TRAP_VECTOR = 1'b0,
      CSR_IRQ_MASK    = 1'b1
   } csr_index_type;

   // Packed with the first field in the highest bits.
   typedef struct packed {
      logic [63:0] pc;
      logic        enable_value;
      logic [5:0]  cause_code;
      logic [2:0]  action;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  previous_mode;
      logic        previous_enable;
      logic        global_enable;
      logic        trap_pending;
      logic [5:0]  latched_cause;
      logic        is_interrupt;
      logic [63:0] saved_pc;
      logic [63:0] target_address;
      logic        redirect;
   } rsp_item_type;

   typedef struct packed {
      logic [63:0]       trap_vector;
      logic [MASK_W-1:0] irq_mask;
   } cfg_type;

endpackage

// File: sv/mtiu_csr.sv
// Configuration registers of the trap unit behind an APB-style port.
// Depends on mtiu_pkg.
module mtiu_csr
   import mtiu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [63:0]       trap_vector_ff, trap_vector_in;
   logic [MASK_W-1:0] irq_mask_ff, irq_mask_in;
   logic              wr_en;
   csr_index_type     idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx        = csr_index_type'(csr_paddr[3]);

   always_comb begin
      trap_vector_in = trap_vector_ff;
      irq_mask_in    = irq_mask_ff;
      if (wr_en) begin
         unique case (idx)
            CSR_TRAP_VECTOR: trap_vector_in = csr_pwdata;
            CSR_IRQ_MASK:    irq_mask_in    = csr_pwdata[MASK_W-1:0];
            default:         ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         CSR_TRAP_VECTOR: csr_prdata = trap_vector_ff;
         CSR_IRQ_MASK:    csr_prdata = {{(CSR_DATA_W-MASK_W){1'b0}}, irq_mask_ff};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trap_vector_ff <= '0;
         irq_mask_ff    <= '0;
      end else begin
         trap_vector_ff <= trap_vector_in;
         irq_mask_ff    <= irq_mask_in;
      end
   end

   assign cfg.trap_vector = trap_vector_ff;
   assign cfg.irq_mask    = irq_mask_ff;

endmodule

// File: sv/mtiu_in_stage.sv
// Input register of the trap unit: holds one request until the core takes it.
// Depends on mtiu_pkg.
module mtiu_in_stage
   import mtiu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output req_item_type out_item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         take;

   // Refill whenever the held request leaves or the stage is empty.
   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      item_in  = take ? in_item : item_ff;
      valid_in = take ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// File: sv/mtiu_core.sv
// Trap state, action decode, interrupt pick, trap entry and result register.
// Depends on mtiu_pkg.
module mtiu_core
   import mtiu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   logic [63:0] pending_ff, pending_in;
   logic        signalled_ff, signalled_in;
   logic        latched_ff, latched_in;
   logic        is_irq_ff, is_irq_in;
   logic [5:0]  cause_ff, cause_in;
   logic        enable_ff, enable_in;
   logic        prev_enable_ff, prev_enable_in;
   logic [1:0]  prev_mode_ff, prev_mode_in;
   logic [1:0]  mode_ff, mode_in;
   logic [63:0] epc_ff, epc_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic              advance;
   logic [MASK_W-1:0] live;
   logic              pick_any;
   logic [5:0]        pick_cause;
   logic              redirect;
   logic [63:0]       target;
   logic [63:0]       vec_offset;
   logic [63:0]       cause_bit;
   action_type        act;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign advance  = in_valid && in_ready;
   assign act      = action_type'(in_item.action);
   assign cause_bit = 64'd1 << in_item.cause_code;

   // Fixed priority: external, then software, then timer.
   assign live     = pending_ff[MASK_W-1:0] & cfg.irq_mask;
   assign pick_any = live[CAUSE_EXT_INT[3:0]] || live[CAUSE_SW_INT[3:0]] ||
                     live[CAUSE_TMR_INT[3:0]];
   always_comb begin
      if (live[CAUSE_EXT_INT[3:0]]) begin
         pick_cause = CAUSE_EXT_INT;
      end else if (live[CAUSE_SW_INT[3:0]]) begin
         pick_cause = CAUSE_SW_INT;
      end else begin
         pick_cause = CAUSE_TMR_INT;
      end
   end

   assign vec_offset = (is_irq_ff && cfg.trap_vector[1:0] == VEC_MODE_VECTORED) ?
                       {56'd0, cause_ff, 2'b00} : 64'd0;

   always_comb begin
      pending_in     = pending_ff;
      signalled_in   = signalled_ff;
      latched_in     = latched_ff;
      is_irq_in      = is_irq_ff;
      cause_in       = cause_ff;
      enable_in      = enable_ff;
      prev_enable_in = prev_enable_ff;
      prev_mode_in   = prev_mode_ff;
      mode_in        = mode_ff;
      epc_in         = epc_ff;
      redirect       = 1'b0;
      target         = 64'd0;
      unique case (act)
         ACT_SET_PENDING: begin
            pending_in   = pending_ff | cause_bit;
            signalled_in = 1'b1;
         end
         ACT_CLEAR_PENDING: begin
            pending_in = pending_ff & ~cause_bit;
         end
         ACT_EXCEPTION: begin
            latched_in = 1'b1;
            is_irq_in  = 1'b0;
            cause_in   = in_item.cause_code;
         end
         ACT_WRITE_ENABLE: begin
            enable_in = in_item.enable_value;
         end
         ACT_STEP: begin
            if (latched_ff) begin
               redirect       = 1'b1;
               target         = {cfg.trap_vector[63:2], 2'b00} + vec_offset;
               latched_in     = 1'b0;
               prev_enable_in = enable_ff;
               enable_in      = 1'b0;
               prev_mode_in   = mode_ff;
               mode_in        = MODE_MACHINE;
               epc_in         = in_item.pc;
            end else if (signalled_ff && enable_ff && pick_any) begin
               latched_in = 1'b1;
               is_irq_in  = 1'b1;
               cause_in   = pick_cause;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_item_in.redirect        = redirect;
      rsp_item_in.target_address  = target;
      rsp_item_in.saved_pc        = epc_in;
      rsp_item_in.is_interrupt    = is_irq_in;
      rsp_item_in.latched_cause   = cause_in;
      rsp_item_in.trap_pending    = latched_in;
      rsp_item_in.global_enable   = enable_in;
      rsp_item_in.previous_enable = prev_enable_in;
      rsp_item_in.previous_mode   = prev_mode_in;
      rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff     <= '0;
         signalled_ff   <= 1'b0;
         latched_ff     <= 1'b0;
         is_irq_ff      <= 1'b0;
         cause_ff       <= '0;
         enable_ff      <= 1'b0;
         prev_enable_ff <= 1'b0;
         prev_mode_ff   <= '0;
         mode_ff        <= MODE_MACHINE;
         epc_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (advance) begin
            pending_ff     <= pending_in;
            signalled_ff   <= signalled_in;
            latched_ff     <= latched_in;
            is_irq_ff      <= is_irq_in;
            cause_ff       <= cause_in;
            enable_ff      <= enable_in;
            prev_enable_ff <= prev_enable_in;
            prev_mode_ff   <= prev_mode_in;
            mode_ff        <= mode_in;
            epc_ff         <= epc_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   a_redirect_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.redirect |->
         !rsp_item_ff.trap_pending && !rsp_item_ff.global_enable)
      else $error("trap entry left a trap latched or interrupts enabled");

   a_target_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_item_ff.redirect |-> rsp_item_ff.target_address == 64'd0)
      else $error("handler address reported without a redirect");

   a_machine_mode: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_MACHINE)
      else $error("privilege mode left machine mode");

   a_entry_consumes: assert property (@(posedge clock) disable iff (reset)
      advance && act == ACT_STEP && latched_ff |=> !latched_ff && epc_ff == $past(in_item.pc))
      else $error("step did not enter the latched trap");

   a_pick_needs_enable: assert property (@(posedge clock) disable iff (reset)
      advance && act == ACT_STEP && !latched_ff && !enable_ff |=> !latched_ff)
      else $error("interrupt latched while globally disabled");
`endif

endmodule

// File: sv/machine_trap_interrupt_unit.sv
// Top level of the machine-mode trap and interrupt unit.
// Depends on mtiu_pkg, mtiu_csr, mtiu_in_stage and mtiu_core.
//
// Each request carries one action (set or clear a pending interrupt, raise an
// exception, write the global enable, or step) and produces exactly one
// response reporting the trap state after that action, plus the handler
// address when a step enters a latched trap. The unit takes one request per
// clock: a request is registered in the input stage, then the decode, the
// fixed-priority interrupt pick (external, software, timer) and the 64-bit
// handler address add run combinationally into the response register, and
// the stream sustains one request per cycle while rsp_tready stays high. While
// a response waits the input stage can still take one request if it is empty;
// beyond that back-pressure stalls both stages in place. The trap vector and
// interrupt mask lie at byte addresses 0 and 8 of the 64-bit register port;
// write them only while no request is in flight.
module machine_trap_interrupt_unit
   import mtiu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // action[2:0], cause_code[8:3], enable_value[9], pc[73:10], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // Response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // redirect[0], target_address[64:1], saved_pc[128:65], is_interrupt[129],
   // latched_cause[135:130], trap_pending[136], global_enable[137],
   // previous_enable[138], previous_mode[140:139], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // Register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int REQ_ITEM_W = $bits(req_item_type);
   localparam int RSP_ITEM_W = $bits(rsp_item_type);

   cfg_type      cfg;
   req_item_type req_item;
   req_item_type stage_item;
   logic         stage_valid;
   logic         stage_ready;
   rsp_item_type rsp_item;

   // Unpack the request; the fill bits above pc are dropped.
   assign req_item = req_item_type'(req_tdata[REQ_ITEM_W-1:0]);

   mtiu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Register the incoming request ahead of the core.
   mtiu_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (stage_valid),
      .out_ready (stage_ready),
      .out_item  (stage_item)
   );

   // Apply the action to the trap state and register the response.
   mtiu_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (stage_valid),
      .in_ready  (stage_ready),
      .in_item   (stage_item),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   // Pack the response, zero fill to whole bytes.
   assign rsp_tdata = {{(RSP_DATA_W-RSP_ITEM_W){1'b0}}, rsp_item};

endmodule
